// ===== rtl/glzw_pkg.sv =====
// Shared constants, types and hash function of the GIF LZW encoder.
package glzw_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int HASH_ENTRIES  = 8192;
    localparam int HASH_AW       = $clog2(HASH_ENTRIES);
    localparam int SYM_W         = 8;
    localparam int KEY_W         = MAX_CODE_BITS + SYM_W;
    localparam int ENTRY_W       = 1 + KEY_W + MAX_CODE_BITS;
    localparam int NFC_W         = MAX_CODE_BITS + 1;
    localparam int CW_W          = $clog2(MAX_CODE_BITS + 1);
    localparam int ACC_W         = MAX_CODE_BITS + 7;
    localparam int CNT_W         = $clog2(ACC_W + 1);
    localparam int SIZE_W        = 4;

    localparam logic [SIZE_W-1:0] MIN_SIZE_RESET = SIZE_W'(8);
    localparam logic [SIZE_W-1:0] MIN_SIZE_LO    = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] MIN_SIZE_HI    = SIZE_W'(8);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAIR,
        ST_PROBE,
        ST_INSERT,
        ST_TAIL,
        ST_ENDC,
        ST_PUT,
        ST_DRAIN,
        ST_CLEAR
    } t_state;

    // key ^ (key >> 11) ^ (key << 5), cut to its low HASH_AW bits
    function automatic logic [HASH_AW-1:0] hash_of(input logic [KEY_W-1:0] key);
        logic [31:0] k;
        logic [31:0] h;
        k = 32'(key);
        h = k ^ (k >> 11) ^ (k << 5);
        return h[HASH_AW-1:0];
    endfunction

endpackage

// ===== rtl/glzw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module glzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gif_lzw_encoder.sv =====
// GIF LZW encoder top level: hash-table dictionary, code packer and byte output.
//
// Input channel: i_valid / o_stall carry one pixel (i_pixel_index, i_last_pixel)
// per transaction. Output channel: o_valid / i_stall carry one packed byte
// (o_code_byte, o_stream_end), LSB first. i_cfg_we writes min_code_size;
// the value is latched when the next stream starts.
// Each pixel is handled by a sequencer around one dictionary RAM (one read,
// one write port, registered read data). A pixel that extends the prefix
// passes through accept, hash read, compare and tail before the next
// transaction, with one more compare per extra probe. A miss adds a merge
// into the bit accumulator, a drain check and an insert, plus one drain step
// per finished byte. The first pixel of a stream also sends the clear code
// (merge, drain check, a drain step per byte); the last pixel sends the prefix
// code, the end code and the partial byte, flagging the final byte with
// o_stream_end, then starts the clearing sweep, which writes all 8192
// dictionary slots invalid, one per cycle, with o_stall high, after reset
// and after every stream end. Configuration writes are taken at any time.
// A byte waits in the output register while i_stall is high; the sequencer
// waits for that register before it produces the next byte.
module gif_lzw_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_pixel_index,
    input  logic       i_last_pixel,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_code_byte,
    output logic       o_stream_end
);

    localparam int MCB = glzw_pkg::MAX_CODE_BITS;
    localparam int AW  = glzw_pkg::HASH_AW;
    localparam int KW  = glzw_pkg::KEY_W;
    localparam int EW  = glzw_pkg::ENTRY_W;
    localparam int NW  = glzw_pkg::NFC_W;
    localparam int CWW = glzw_pkg::CW_W;
    localparam int AXW = glzw_pkg::ACC_W;
    localparam int CNW = glzw_pkg::CNT_W;
    localparam int SW  = glzw_pkg::SIZE_W;

    // sequencer and stream state
    glzw_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [SW-1:0]  r_min, n_min, r_as, n_as;
    logic           r_started, n_started, r_have, n_have;
    logic [MCB-1:0] r_prefix, n_prefix;
    logic [NW-1:0]  r_nfc, n_nfc;
    logic [CWW-1:0] r_cw, n_cw;
    logic [7:0]     r_pix, n_pix;
    logic           r_last, n_last;
    logic [7:0]     r_sym, n_sym;
    logic [KW-1:0]  r_key, n_key;
    logic [AW-1:0]  r_idx, n_idx, r_clr, n_clr;
    // code packer
    logic [MCB-1:0] r_code, n_code;
    logic [CWW-1:0] r_w, n_w;
    logic           r_final, n_final;
    logic [AXW-1:0] r_acc, n_acc;
    logic [CNW-1:0] r_cnt, n_cnt;
    // output register
    logic           r_ov, n_ov, r_oe, n_oe;
    logic [7:0]     r_ob, n_ob;

    // dictionary port
    logic           mem_we;
    logic [AW-1:0]  mem_waddr, mem_raddr;
    logic [EW-1:0]  mem_wdata, mem_rdata;

    logic           ent_valid, ent_hit, slot_free, accept;
    logic [KW-1:0]  ent_key;
    logic [MCB-1:0] ent_code, clear_code, code_mask;
    logic [SW-1:0]  size_new;
    logic [KW-1:0]  pair_key;
    logic [NW-1:0]  nfc_inc, cw_pow;

    glzw_ram #(
        .WIDTH (EW),
        .DEPTH (glzw_pkg::HASH_ENTRIES)
    ) u_dict (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign ent_valid  = mem_rdata[EW-1];
    assign ent_key    = mem_rdata[EW-2 -: KW];
    assign ent_code   = mem_rdata[MCB-1:0];
    assign ent_hit    = ent_valid && (ent_key == r_key);
    assign slot_free  = !r_ov || !i_stall;
    assign accept     = i_valid && !o_stall;
    assign clear_code = MCB'(1) << r_as;
    assign code_mask  = MCB'((32'd1 << r_w) - 32'd1);
    assign pair_key   = {r_prefix, r_sym};
    assign nfc_inc    = r_nfc + NW'(1);
    assign cw_pow     = NW'(1) << r_cw;

    always_comb begin
        if (r_min < glzw_pkg::MIN_SIZE_LO) begin
            size_new = glzw_pkg::MIN_SIZE_LO;
        end else if (r_min > glzw_pkg::MIN_SIZE_HI) begin
            size_new = glzw_pkg::MIN_SIZE_HI;
        end else begin
            size_new = r_min;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            glzw_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = r_started ? glzw_pkg::ST_PAIR : glzw_pkg::ST_PUT;
                end
            end
            glzw_pkg::ST_PAIR:   n_state = r_have ? glzw_pkg::ST_PROBE : glzw_pkg::ST_TAIL;
            glzw_pkg::ST_PROBE: begin
                if (!ent_valid) begin
                    n_state = glzw_pkg::ST_PUT;
                end else if (ent_hit) begin
                    n_state = glzw_pkg::ST_TAIL;
                end
            end
            glzw_pkg::ST_INSERT: n_state = glzw_pkg::ST_TAIL;
            glzw_pkg::ST_TAIL:   n_state = r_last ? glzw_pkg::ST_PUT : glzw_pkg::ST_IDLE;
            glzw_pkg::ST_ENDC:   n_state = glzw_pkg::ST_PUT;
            glzw_pkg::ST_PUT:    n_state = glzw_pkg::ST_DRAIN;
            glzw_pkg::ST_DRAIN: begin
                if (r_cnt == '0 || (r_cnt < CNW'(8) && !r_final)) begin
                    n_state = r_ret;
                end
            end
            glzw_pkg::ST_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = glzw_pkg::ST_IDLE;
                end
            end
            default: n_state = glzw_pkg::ST_CLEAR;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_ret     = r_ret;
        n_min     = i_cfg_we ? i_cfg_data : r_min;
        n_as      = r_as;
        n_started = r_started;
        n_have    = r_have;
        n_prefix  = r_prefix;
        n_nfc     = r_nfc;
        n_cw      = r_cw;
        n_pix     = r_pix;
        n_last    = r_last;
        n_sym     = r_sym;
        n_key     = r_key;
        n_idx     = r_idx;
        n_clr     = r_clr;
        n_code    = r_code;
        n_w       = r_w;
        n_final   = r_final;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_ov      = r_ov && i_stall;
        n_oe      = r_oe;
        n_ob      = r_ob;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = {1'b1, r_key, r_nfc[MCB-1:0]};
        mem_raddr = r_idx + AW'(1);
        o_stall   = (r_state != glzw_pkg::ST_IDLE);

        unique case (r_state)
            glzw_pkg::ST_IDLE: begin
                if (accept) begin
                    n_pix  = i_pixel_index;
                    n_last = i_last_pixel;
                    if (!r_started) begin
                        // new stream: latch size, send clear code
                        n_as      = size_new;
                        n_nfc     = (NW'(1) << size_new) + NW'(2);
                        n_cw      = CWW'(size_new) + CWW'(1);
                        n_code    = MCB'(1) << size_new;
                        n_w       = CWW'(size_new) + CWW'(1);
                        n_started = 1'b1;
                        n_ret     = glzw_pkg::ST_PAIR;
                    end
                end
            end
            glzw_pkg::ST_PAIR: begin
                n_sym = r_pix & clear_code[7:0] - 8'd1;
                if (clear_code[8]) begin
                    n_sym = r_pix;
                end
                n_key     = {r_prefix, n_sym};
                n_idx     = glzw_pkg::hash_of(n_key);
                mem_raddr = n_idx;
                if (!r_have) begin
                    n_prefix = MCB'(n_sym);
                    n_have   = 1'b1;
                end
            end
            glzw_pkg::ST_PROBE: begin
                if (!ent_valid) begin
                    n_code = r_prefix;
                    n_w    = r_cw;
                    n_ret  = glzw_pkg::ST_INSERT;
                end else if (ent_hit) begin
                    n_prefix = ent_code;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            glzw_pkg::ST_INSERT: begin
                if (r_nfc < (NW'(1) << MCB)) begin
                    mem_we = 1'b1;
                    n_nfc  = nfc_inc;
                    if (nfc_inc > cw_pow && r_cw < CWW'(MCB)) begin
                        n_cw = r_cw + CWW'(1);
                    end
                end
                n_prefix = MCB'(r_sym);
            end
            glzw_pkg::ST_TAIL: begin
                if (r_last) begin
                    n_code = r_prefix;
                    n_w    = r_cw;
                    n_ret  = glzw_pkg::ST_ENDC;
                end
            end
            glzw_pkg::ST_ENDC: begin
                n_code  = clear_code + MCB'(1);
                n_w     = r_cw;
                if (r_nfc == cw_pow && r_cw < CWW'(MCB)) begin
                    n_w = r_cw + CWW'(1);
                end
                n_final = 1'b1;
                n_ret   = glzw_pkg::ST_CLEAR;
            end
            glzw_pkg::ST_PUT: begin
                n_acc = r_acc | (AXW'(r_code & code_mask) << r_cnt);
                n_cnt = r_cnt + CNW'(r_w);
            end
            glzw_pkg::ST_DRAIN: begin
                if (slot_free && r_cnt >= CNW'(8)) begin
                    n_ov  = 1'b1;
                    n_ob  = r_acc[7:0];
                    n_oe  = r_final && (r_cnt == CNW'(8));
                    n_acc = r_acc >> 8;
                    n_cnt = r_cnt - CNW'(8);
                end else if (slot_free && r_final && r_cnt != '0 && r_cnt < CNW'(8)) begin
                    // partial last byte
                    n_ov  = 1'b1;
                    n_ob  = r_acc[7:0];
                    n_oe  = 1'b1;
                    n_acc = '0;
                    n_cnt = '0;
                end
            end
            glzw_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == '1) begin
                    n_started = 1'b0;
                    n_have    = 1'b0;
                    n_prefix  = '0;
                    n_final   = 1'b0;
                end
            end
            default: begin
                n_final = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= glzw_pkg::ST_CLEAR;
            r_ret     <= glzw_pkg::ST_IDLE;
            r_min     <= glzw_pkg::MIN_SIZE_RESET;
            r_as      <= glzw_pkg::MIN_SIZE_RESET;
            r_started <= 1'b0;
            r_have    <= 1'b0;
            r_prefix  <= '0;
            r_nfc     <= '0;
            r_cw      <= '0;
            r_clr     <= '0;
            r_final   <= 1'b0;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_min     <= n_min;
            r_as      <= n_as;
            r_started <= n_started;
            r_have    <= n_have;
            r_prefix  <= n_prefix;
            r_nfc     <= n_nfc;
            r_cw      <= n_cw;
            r_clr     <= n_clr;
            r_final   <= n_final;
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_ov      <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pix  <= n_pix;
        r_last <= n_last;
        r_sym  <= n_sym;
        r_key  <= n_key;
        r_idx  <= n_idx;
        r_code <= n_code;
        r_w    <= n_w;
        r_ob   <= n_ob;
        r_oe   <= n_oe;
    end

    assign o_valid      = r_ov;
    assign o_code_byte  = r_ob;
    assign o_stream_end = r_oe;

    // no pixel enters during the dictionary sweep
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == glzw_pkg::ST_CLEAR) |-> !accept)
        else $error("pixel accepted during clear sweep");

    // every full byte is drained from the bit accumulator before the next pixel
    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == glzw_pkg::ST_IDLE) |-> (r_cnt < CNW'(8)))
        else $error("bit accumulator holds a full byte while idle");

    // code width never passes the limit
    a_cw_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cw <= CWW'(MCB)))
        else $error("code width above maximum");

    // a byte is never dropped while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_ov && $stable(r_ob)))
        else $error("stalled output byte lost");

endmodule
